>>> design/c2p_pkg.sv
package c2p_pkg;

  localparam int CW = 64;
  localparam int ZW = 35;
  localparam int GUARD_BASE = 60;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    logic valid;
    logic fix;
  } ctl_t;

  // atan(2^-i) * 2^30, truncated
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  localparam ang_t PI_Z      = 35'sh0C90FDAA0;
  localparam ang_t HALF_PI_Z = 35'sh06487ED50;

  // 2^30-scaled angle down by sh bits, round half up
  function automatic ang_t z_round(input ang_t z, input int unsigned sh);
    ang_t h;
    h = ang_t'(1) <<< (sh - 1);
    return (z + h) >>> sh;
  endfunction

endpackage

>>> design/c2p_in_if.sv
interface c2p_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

>>> design/c2p_out_if.sv
interface c2p_out_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic        [COORD_BITS-1:0] magnitude;
  logic signed [COORD_BITS-1:0] angle;

  modport source (output valid, output magnitude, output angle, input ready);
  modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

>>> design/c2p_front.sv
module c2p_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  c2p_in_if.sink                    in_chan,
  input  logic                      ready_dn,
  output c2p_pkg::ctl_t             ctl_o,
  output c2p_pkg::crd_t             cx_o,
  output c2p_pkg::crd_t             cy_o,
  output c2p_pkg::ang_t             z_o,
  output logic [2*COORD_BITS-1:0]   rem_o,
  output logic [2*COORD_BITS:0]     res_o
);
  import c2p_pkg::*;

  localparam int W     = COORD_BITS;
  localparam int RW    = 2 * W;
  localparam int GUARD = GUARD_BASE - W;
  localparam int EXT   = CW - (W + 1) - GUARD;

  logic signed [W:0] xe, ye, v_cx, v_cy;
  logic              x_zero, y_zero, x_neg, y_neg;
  logic [W-1:0]      ux, uy;

  logic              va_r, vb_r;
  logic              rdy_a, rdy_b;
  logic              fixa_r, fixa_nxt, fixb_r;
  logic [RW-1:0]     sqx_r, sqy_r, sqx_nxt, sqy_nxt, sum_r;
  crd_t              cxa_r, cya_r, cxa_nxt, cya_nxt, cxb_r, cyb_r;
  ang_t              za_r, za_nxt, zb_r;

  assign xe     = (W + 1)'(in_chan.coord_x);
  assign ye     = (W + 1)'(in_chan.coord_y);
  assign x_zero = (in_chan.coord_x == '0);
  assign y_zero = (in_chan.coord_y == '0);
  assign x_neg  = in_chan.coord_x[W-1];
  assign y_neg  = in_chan.coord_y[W-1];
  assign ux     = x_neg ? W'(-xe) : W'(xe);
  assign uy     = y_neg ? W'(-ye) : W'(ye);

  assign sqx_nxt = RW'(ux) * RW'(ux);
  assign sqy_nxt = RW'(uy) * RW'(uy);

  // quadrant fold into the right half plane, axis points fix the angle here
  always_comb begin
    fixa_nxt = 1'b0;
    za_nxt   = '0;
    v_cx     = xe;
    v_cy     = ye;
    if (y_zero) begin
      fixa_nxt = 1'b1;
      za_nxt   = x_neg ? PI_Z : '0;
    end else if (x_zero) begin
      fixa_nxt = 1'b1;
      za_nxt   = y_neg ? -HALF_PI_Z : HALF_PI_Z;
    end else if (!x_neg) begin
      v_cx = xe;
      v_cy = ye;
    end else if (!y_neg) begin
      v_cx   = ye;
      v_cy   = -xe;
      za_nxt = HALF_PI_Z;
    end else begin
      v_cx   = -ye;
      v_cy   = xe;
      za_nxt = -HALF_PI_Z;
    end
  end

  assign cxa_nxt = {{EXT{v_cx[W]}}, v_cx, {GUARD{1'b0}}};
  assign cya_nxt = {{EXT{v_cy[W]}}, v_cy, {GUARD{1'b0}}};

  assign rdy_b         = !vb_r || ready_dn;
  assign rdy_a         = !va_r || rdy_b;
  assign in_chan.ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_chan.valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      fixa_r <= fixa_nxt;
      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
      cxa_r  <= cxa_nxt;
      cya_r  <= cya_nxt;
      za_r   <= za_nxt;
    end
    if (rdy_b) begin
      fixb_r <= fixa_r;
      sum_r  <= sqx_r + sqy_r;
      cxb_r  <= cxa_r;
      cyb_r  <= cya_r;
      zb_r   <= za_r;
    end
  end

  assign ctl_o = '{valid: vb_r, fix: fixb_r};
  assign cx_o  = cxb_r;
  assign cy_o  = cyb_r;
  assign z_o   = zb_r;
  assign rem_o = sum_r;
  assign res_o = '0;

endmodule

>>> design/c2p_cell.sv
module c2p_cell #(
  parameter int COORD_BITS = 16,
  parameter int ITERATIONS = 16,
  parameter int IDX        = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  c2p_pkg::ctl_t             ctl_i,
  input  c2p_pkg::crd_t             cx_i,
  input  c2p_pkg::crd_t             cy_i,
  input  c2p_pkg::ang_t             z_i,
  input  logic [2*COORD_BITS-1:0]   rem_i,
  input  logic [2*COORD_BITS:0]     res_i,
  output logic                      ready_up,
  input  logic                      ready_dn,
  output c2p_pkg::ctl_t             ctl_o,
  output c2p_pkg::crd_t             cx_o,
  output c2p_pkg::crd_t             cy_o,
  output c2p_pkg::ang_t             z_o,
  output logic [2*COORD_BITS-1:0]   rem_o,
  output logic [2*COORD_BITS:0]     res_o
);
  import c2p_pkg::*;

  localparam int RW      = 2 * COORD_BITS;
  localparam int SW      = RW + 1;
  localparam bit DO_ROT  = (IDX < ITERATIONS);
  localparam bit DO_SQRT = (IDX < COORD_BITS);
  localparam int K       = IDX % 32;
  localparam int SH      = DO_SQRT ? (RW - 2 - 2 * IDX) : 0;
  localparam logic [SW-1:0] BIT    = SW'(1) << SH;
  localparam ang_t          ATAN_K = ang_t'(ATAN_TAB[K]);

  logic          valid_r, fix_r;
  crd_t          cx_r, cy_r, cx_nxt, cy_nxt;
  ang_t          z_r, z_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] res_r, res_nxt, t;

  always_comb begin
    cx_nxt  = cx_i;
    cy_nxt  = cy_i;
    z_nxt   = z_i;
    rem_nxt = rem_i;
    res_nxt = res_i;
    t       = res_i + BIT;
    if (DO_ROT) begin
      if (!cy_i[CW-1]) begin
        cx_nxt = cx_i + (cy_i >>> K);
        cy_nxt = cy_i - (cx_i >>> K);
        if (!ctl_i.fix) z_nxt = z_i + ATAN_K;
      end else begin
        cx_nxt = cx_i - (cy_i >>> K);
        cy_nxt = cy_i + (cx_i >>> K);
        if (!ctl_i.fix) z_nxt = z_i - ATAN_K;
      end
    end
    if (DO_SQRT) begin
      if ({1'b0, rem_i} >= t) begin
        rem_nxt = rem_i - t[RW-1:0];
        res_nxt = (res_i >> 1) + BIT;
      end else begin
        res_nxt = res_i >> 1;
      end
    end
  end

  assign ready_up = !valid_r || ready_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_up) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      fix_r <= ctl_i.fix;
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      z_r   <= z_nxt;
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

  assign ctl_o = '{valid: valid_r, fix: fix_r};
  assign cx_o  = cx_r;
  assign cy_o  = cy_r;
  assign z_o   = z_r;
  assign rem_o = rem_r;
  assign res_o = res_r;

endmodule

>>> design/c2p_back.sv
module c2p_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  c2p_pkg::ctl_t             ctl_i,
  input  c2p_pkg::ang_t             z_i,
  input  logic [2*COORD_BITS-1:0]   rem_i,
  input  logic [2*COORD_BITS:0]     res_i,
  output logic                      ready_up,
  c2p_out_if.source                 out_chan
);
  import c2p_pkg::*;

  localparam int   W   = COORD_BITS;
  localparam int   SH  = 33 - W;
  localparam ang_t LIM = z_round(PI_Z, SH);

  ang_t         a;
  logic         valid_r;
  logic [W-1:0] mag_r, mag_nxt, ang_r, ang_nxt;

  always_comb begin
    a = z_round(z_i, SH);
    if (a > LIM) begin
      a = LIM;
    end else if (a < -LIM) begin
      a = -LIM;
    end
  end

  assign ang_nxt = a[W-1:0];
  assign mag_nxt = W'(res_i) + W'({1'b0, rem_i} > res_i);

  assign ready_up = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_up) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      mag_r <= mag_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign out_chan.valid     = valid_r;
  assign out_chan.magnitude = mag_r;
  assign out_chan.angle     = ang_r;

endmodule

>>> design/cartesian_to_polar.sv
// Throughput: one request per cycle while the result side does not stall; two front
// stages, one cell per CORDIC micro-rotation and square-root digit, and one output
// register, each with its own valid bit.
// Stalls on the result side propagate back stage by stage; bubbles are squeezed out.
// Reset (rst_n, synchronous, active low) clears all valid bits; no other state.
module cartesian_to_polar #(
  parameter int COORD_BITS = 16,
  parameter int ITERATIONS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  c2p_in_if.sink    in_chan,
  c2p_out_if.source out_chan
);
  import c2p_pkg::*;

  localparam int N  = (COORD_BITS > ITERATIONS) ? COORD_BITS : ITERATIONS;
  localparam int RW = 2 * COORD_BITS;
  localparam ang_t ANG_LIM = z_round(PI_Z, 33 - COORD_BITS);

  ctl_t          ctl [0:N];
  crd_t          cx  [0:N];
  crd_t          cy  [0:N];
  ang_t          z   [0:N];
  logic [RW-1:0] rem [0:N];
  logic [RW:0]   res [0:N];
  logic          rdy [0:N];

  c2p_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .ready_dn (rdy[0]),
    .ctl_o    (ctl[0]),
    .cx_o     (cx[0]),
    .cy_o     (cy[0]),
    .z_o      (z[0]),
    .rem_o    (rem[0]),
    .res_o    (res[0])
  );

  for (genvar j = 0; j < N; j++) begin : g_cell
    c2p_cell #(
      .COORD_BITS (COORD_BITS),
      .ITERATIONS (ITERATIONS),
      .IDX        (j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_i    (ctl[j]),
      .cx_i     (cx[j]),
      .cy_i     (cy[j]),
      .z_i      (z[j]),
      .rem_i    (rem[j]),
      .res_i    (res[j]),
      .ready_up (rdy[j]),
      .ready_dn (rdy[j+1]),
      .ctl_o    (ctl[j+1]),
      .cx_o     (cx[j+1]),
      .cy_o     (cy[j+1]),
      .z_o      (z[j+1]),
      .rem_o    (rem[j+1]),
      .res_o    (res[j+1])
    );
  end

  c2p_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl[N]),
    .z_i      (z[N]),
    .rem_i    (rem[N]),
    .res_i    (res[N]),
    .ready_up (rdy[N]),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_chan.valid |-> in_chan.ready)
    else $error("input stalled with empty output register");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (ang_t'(out_chan.angle) <= ANG_LIM) &&
                       (ang_t'(out_chan.angle) >= -ANG_LIM))
    else $error("angle outside [-pi, pi]");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ctl[0].valid && !rdy[0] |=> ctl[0].valid && $stable(z[0]) && $stable(rem[0]))
    else $error("front stage lost a request under stall");
`endif

endmodule
